// ----- rtl/afc_pkg.sv -----
// afc_pkg: widths, item/plane types and helpers for the AABB frustum culler.
// Used by afc_cell, aabb_frustum_cull and the testbench; depends on nothing.

package afc_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int ENTRY_WIDTH     = 16;
    localparam int SLOT_WIDTH      = 16;
    localparam int NUM_PLANES      = 5;
    localparam int NUM_COLS        = 4;
    localparam int NUM_ROWS        = 4;
    localparam int ROW_WIDTH       = $clog2(NUM_ROWS);
    localparam int NORM_WIDTH      = ENTRY_WIDTH + 1;
    localparam int PROD_WIDTH      = NORM_WIDTH + COORD_WIDTH;
    localparam int SUM_WIDTH       = PROD_WIDTH + 2;
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = SLOT_WIDTH * NUM_ROWS;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MATRIX_COL0 = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MATRIX_COL1 = CFG_INDEX_WIDTH'(1);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MATRIX_COL2 = CFG_INDEX_WIDTH'(2);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MATRIX_COL3 = CFG_INDEX_WIDTH'(3);

    // Matrix row that holds the w terms
    localparam logic [ROW_WIDTH-1:0] ROW_W = ROW_WIDTH'(3);

    typedef logic [CFG_DATA_WIDTH-1:0]     column_t;
    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [ENTRY_WIDTH-1:0] entry_t;
    typedef logic signed [NORM_WIDTH-1:0]  norm_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [SUM_WIDTH-1:0]   sum_t;

    typedef struct packed {
        coord_t lo_x;
        coord_t lo_y;
        coord_t lo_z;
        coord_t hi_x;
        coord_t hi_y;
        coord_t hi_z;
    } box_t;

    typedef struct packed {
        norm_t nx;
        norm_t ny;
        norm_t nz;
        norm_t d;
        logic  skip;    // zero normal: plane always passes
    } plane_t;

    typedef struct packed {
        logic valid;
        logic visible;
        box_t box;
    } token_t;

    // Planes 0..4: left, right, bottom, top, near
    function automatic logic [ROW_WIDTH-1:0] plane_row(input int p);
        plane_row = ROW_WIDTH'(p >> 1);
    endfunction

    function automatic logic plane_minus(input int p);
        plane_minus = (p & 1) != 0;
    endfunction

    function automatic entry_t entry_of(input column_t col, input logic [ROW_WIDTH-1:0] row);
        entry_of = entry_t'(col[SLOT_WIDTH*row +: ENTRY_WIDTH]);
    endfunction

    function automatic norm_t combine(input entry_t a, input entry_t b, input logic minus);
        combine = minus ? (norm_t'(a) - norm_t'(b)) : (norm_t'(a) + norm_t'(b));
    endfunction

    // Positive vertex coordinate: max corner for a non-negative component
    function automatic coord_t pick(input norm_t n, input coord_t lo, input coord_t hi);
        pick = n[NORM_WIDTH-1] ? lo : hi;
    endfunction

endpackage

// ----- rtl/afc_cell.sv -----
// afc_cell: one plane test in the culling chain, two register stages.
// Depends on afc_pkg.

module afc_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  afc_pkg::plane_t plane,
    input  afc_pkg::token_t up,
    output afc_pkg::token_t down
);

    // stage A: products of the normal and the positive vertex
    logic            a_valid_reg;
    logic            a_visible_reg;
    afc_pkg::box_t   a_box_reg;
    afc_pkg::prod_t  a_prod_x_reg;
    afc_pkg::prod_t  a_prod_y_reg;
    afc_pkg::prod_t  a_prod_z_reg;
    afc_pkg::norm_t  a_d_reg;
    logic            a_skip_reg;

    afc_pkg::prod_t  a_prod_x_next;
    afc_pkg::prod_t  a_prod_y_next;
    afc_pkg::prod_t  a_prod_z_next;

    // stage B: sum, sign test, visible flag
    logic            b_valid_reg;
    logic            b_visible_reg;
    afc_pkg::box_t   b_box_reg;

    afc_pkg::sum_t   sum;
    logic            b_visible_next;

    assign a_prod_x_next = afc_pkg::prod_t'(plane.nx)
        * afc_pkg::prod_t'(afc_pkg::pick(plane.nx, up.box.lo_x, up.box.hi_x));
    assign a_prod_y_next = afc_pkg::prod_t'(plane.ny)
        * afc_pkg::prod_t'(afc_pkg::pick(plane.ny, up.box.lo_y, up.box.hi_y));
    assign a_prod_z_next = afc_pkg::prod_t'(plane.nz)
        * afc_pkg::prod_t'(afc_pkg::pick(plane.nz, up.box.lo_z, up.box.hi_z));

    assign sum = afc_pkg::sum_t'(a_prod_x_reg) + afc_pkg::sum_t'(a_prod_y_reg)
               + afc_pkg::sum_t'(a_prod_z_reg) + afc_pkg::sum_t'(a_d_reg);

    assign b_visible_next = a_visible_reg & (a_skip_reg | ~sum[afc_pkg::SUM_WIDTH-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= up.valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_visible_reg <= up.visible;
            a_box_reg     <= up.box;
            a_prod_x_reg  <= a_prod_x_next;
            a_prod_y_reg  <= a_prod_y_next;
            a_prod_z_reg  <= a_prod_z_next;
            a_d_reg       <= plane.d;
            a_skip_reg    <= plane.skip;
            b_visible_reg <= b_visible_next;
            b_box_reg     <= a_box_reg;
        end
    end

    assign down.valid   = b_valid_reg;
    assign down.visible = b_visible_reg;
    assign down.box     = b_box_reg;

endmodule

// ----- rtl/aabb_frustum_cull.sv -----
// aabb_frustum_cull: top level of the AABB-versus-frustum culler.
// Depends on afc_pkg and afc_cell.

// Each box item flows through a chain of five plane cells (left, right,
// bottom, top, near; no far plane), one cell per plane, each cell two
// register stages deep. One box is taken per clock while the chain is
// not stalled; its result passes through the five cells of two stages
// each (multiply stage, then sum and sign stage). The chain moves as one:
// when the output register holds an untaken result the whole chain and
// box_ready stall, so box_ready = !result_valid | result_ready.
// The matrix sits in four 64-bit column registers written on the cfg port
// (index 0..3, other indexes ignored, cfg_ready always high). Plane
// coefficients are row 3 plus or minus rows 0..2, computed from the
// columns, registered in the cycle after a write; writes are expected only
// while the culler is empty. A plane with an all-zero normal always passes.
// A box is culled (visible = 0) when for some plane the positive vertex
// gives dot(n, v) + d < 0; the sum is exact, so nothing saturates.

module aabb_frustum_cull
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [afc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [afc_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,

    input  logic                                  box_valid,
    output logic                                  box_ready,
    input  logic signed [afc_pkg::COORD_WIDTH-1:0] box_min_x,
    input  logic signed [afc_pkg::COORD_WIDTH-1:0] box_min_y,
    input  logic signed [afc_pkg::COORD_WIDTH-1:0] box_min_z,
    input  logic signed [afc_pkg::COORD_WIDTH-1:0] box_max_x,
    input  logic signed [afc_pkg::COORD_WIDTH-1:0] box_max_y,
    input  logic signed [afc_pkg::COORD_WIDTH-1:0] box_max_z,

    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic                                  visible
);

    afc_pkg::column_t matrix_col_reg [afc_pkg::NUM_COLS];
    afc_pkg::plane_t  plane_reg      [afc_pkg::NUM_PLANES];
    afc_pkg::plane_t  plane_next     [afc_pkg::NUM_PLANES];
    afc_pkg::token_t  tok            [afc_pkg::NUM_PLANES+1];
    logic             en;

    assign cfg_ready = 1'b1;

    // Matrix column registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < afc_pkg::NUM_COLS; c++)
            begin
                matrix_col_reg[c] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                afc_pkg::REG_MATRIX_COL0: matrix_col_reg[0] <= cfg_data;
                afc_pkg::REG_MATRIX_COL1: matrix_col_reg[1] <= cfg_data;
                afc_pkg::REG_MATRIX_COL2: matrix_col_reg[2] <= cfg_data;
                afc_pkg::REG_MATRIX_COL3: matrix_col_reg[3] <= cfg_data;
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    // Plane extraction: n = row3 +/- row k per column, d from column 3
    for (genvar p = 0; p < afc_pkg::NUM_PLANES; p++)
    begin : g_plane
        localparam logic [afc_pkg::ROW_WIDTH-1:0] ROW = afc_pkg::plane_row(p);
        localparam logic MINUS = afc_pkg::plane_minus(p);

        always_comb
        begin
            plane_next[p].nx = afc_pkg::combine(
                afc_pkg::entry_of(matrix_col_reg[0], afc_pkg::ROW_W),
                afc_pkg::entry_of(matrix_col_reg[0], ROW), MINUS);
            plane_next[p].ny = afc_pkg::combine(
                afc_pkg::entry_of(matrix_col_reg[1], afc_pkg::ROW_W),
                afc_pkg::entry_of(matrix_col_reg[1], ROW), MINUS);
            plane_next[p].nz = afc_pkg::combine(
                afc_pkg::entry_of(matrix_col_reg[2], afc_pkg::ROW_W),
                afc_pkg::entry_of(matrix_col_reg[2], ROW), MINUS);
            plane_next[p].d = afc_pkg::combine(
                afc_pkg::entry_of(matrix_col_reg[3], afc_pkg::ROW_W),
                afc_pkg::entry_of(matrix_col_reg[3], ROW), MINUS);
            plane_next[p].skip = (plane_next[p].nx == '0) && (plane_next[p].ny == '0)
                              && (plane_next[p].nz == '0);
        end

        // Follows the matrix every cycle; the user must keep it stable while items are in flight (not enforced here)
        always_ff @(posedge clk)
        begin
            plane_reg[p] <= plane_next[p];
        end
    end

    // Whole chain advances unless the output holds an untaken result
    assign en        = !tok[afc_pkg::NUM_PLANES].valid || result_ready;
    assign box_ready = en;

    assign tok[0].valid      = box_valid;
    assign tok[0].visible    = 1'b1;
    assign tok[0].box.lo_x   = box_min_x;
    assign tok[0].box.lo_y   = box_min_y;
    assign tok[0].box.lo_z   = box_min_z;
    assign tok[0].box.hi_x   = box_max_x;
    assign tok[0].box.hi_y   = box_max_y;
    assign tok[0].box.hi_z   = box_max_z;

    for (genvar p = 0; p < afc_pkg::NUM_PLANES; p++)
    begin : g_cell
        afc_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .plane (plane_reg[p]),
            .up    (tok[p]),
            .down  (tok[p+1])
        );
    end

    // Last cell's stage B is the output register
    assign result_valid = tok[afc_pkg::NUM_PLANES].valid;
    assign visible      = tok[afc_pkg::NUM_PLANES].visible;

endmodule

// ----- rtl/afc_checker.sv -----
// afc_checker: port-level assertions for aabb_frustum_cull, bound to the top.
// Depends on aabb_frustum_cull port names.

module afc_checker
(
    input logic clk,
    input logic rst_n,
    input logic box_valid,
    input logic box_ready,
    input logic cfg_ready,
    input logic result_valid,
    input logic result_ready,
    input logic visible
);

    // Input side stalls exactly when a result waits untaken
    a_ready_tracks_output: assert property (@(posedge clk) disable iff (!rst_n)
        box_ready == (!result_valid || result_ready))
        else $error("box_ready does not follow output stall");

    // Config port never back-pressures
    a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("cfg_ready dropped");

    // A stalled result stays put
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(visible))
        else $error("stalled result changed");

    // A result leaves only through a handshake
    a_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(result_valid) |-> $past(result_ready))
        else $error("result dropped without handshake");

endmodule

bind aabb_frustum_cull afc_checker u_afc_checker (.*);

// ----- sim/aabb_frustum_cull_test.sv -----
// aabb_frustum_cull_test: self-checking bench for the five-plane AABB frustum culler.
// Depends on afc_pkg and aabb_frustum_cull from rtl/; drives the cfg, box and result
// channels and checks every visible flag against an in-bench plane predictor.

module aabb_frustum_cull_test;

    // Watchdog: cycles with no handshake on any channel before the run is abandoned.
    // Far above the long receiver hold-off and the longest sender gap.
    localparam int IDLE_LIMIT   = 2000;
    // Cycles the receiver holds off once, to back the chain up into box_ready.
    localparam int HOLD_CYCLES  = 150;
    // Tail wait at phase ends, longer than the chain is deep.
    localparam int TAIL_CYCLES  = 14;
    localparam int SETTLE_CYCLES = 3;
    localparam int PHASE_ITEMS  = 145;
    localparam int MAX_PRINTS   = 40;

    typedef enum int {
        MX_RANDOM,
        MX_MAX,
        MX_MIN,
        MX_MIXED,
        MX_PROJ,
        MX_FLAT,
        MX_SMALL,
        MX_ZERO
    } matrix_kind_t;

    // ------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the four matrix columns, predicts
    // the visible flag for each accepted box and checks results in order.
    // ------------------------------------------------------------------
    class cull_scoreboard;
        afc_pkg::column_t cols[afc_pkg::NUM_COLS];
        logic    visible_q[$];
        int      errors;
        int      checked;

        function new();
            for (int c = 0; c < afc_pkg::NUM_COLS; c++)
                cols[c] = '0;
            errors  = 0;
            checked = 0;
        endfunction

        // Indexes past the last column are dropped, as in the block.
        function void set_column(logic [afc_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                 afc_pkg::column_t data);
            if (idx <= afc_pkg::REG_MATRIX_COL3)
                cols[idx] = data;
        endfunction

        function longint entry(int c, int r);
            afc_pkg::entry_t e;
            e = cols[c][afc_pkg::SLOT_WIDTH*r +: afc_pkg::ENTRY_WIDTH];
            return longint'(e);
        endfunction

        // Plane p: row 3 plus (left, bottom, near) or minus (right, top) row p/2.
        function logic visible_of(afc_pkg::box_t b);
            longint lo[3];
            longint hi[3];
            longint n[3];
            longint d;
            longint acc;
            longint a;
            longint m;
            int     row;
            int     w_row;
            bit     minus;
            bit     flat;
            logic   vis;
            vis   = 1'b1;
            w_row = int'(afc_pkg::ROW_W);
            lo[0] = b.lo_x;
            lo[1] = b.lo_y;
            lo[2] = b.lo_z;
            hi[0] = b.hi_x;
            hi[1] = b.hi_y;
            hi[2] = b.hi_z;
            for (int p = 0; p < afc_pkg::NUM_PLANES; p++) begin
                if (vis) begin
                    row   = p >> 1;
                    minus = (p % 2) == 1;
                    flat  = 1'b1;
                    for (int c = 0; c < 3; c++) begin
                        a    = entry(c, w_row);
                        m    = entry(c, row);
                        n[c] = minus ? a - m : a + m;
                        if (n[c] != 0)
                            flat = 1'b0;
                    end
                    a = entry(3, w_row);
                    m = entry(3, row);
                    d = minus ? a - m : a + m;
                    // all-zero normal: plane never culls, whatever d is
                    if (!flat) begin
                        acc = d;
                        for (int c = 0; c < 3; c++)
                            acc += n[c] * ((n[c] >= 0) ? hi[c] : lo[c]);
                        if (acc < 0)
                            vis = 1'b0;
                    end
                end
            end
            return vis;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("mismatch: %s", msg);
        endtask

        function void note_box(afc_pkg::box_t b);
            visible_q.push_back(visible_of(b));
        endfunction

        task check_visible(logic got);
            logic want;
            checked++;
            if (visible_q.size() == 0) begin
                report($sformatf("result %0d (visible=%b) with no box pending", checked, got));
            end
            else begin
                want = visible_q.pop_front();
                if (got !== want)
                    report($sformatf("result %0d: visible got %b, want %b",
                                     checked, got, want));
            end
        endtask

        function int pending();
            return visible_q.size();
        endfunction

        task close_out();
            if (visible_q.size() != 0)
                report($sformatf("%0d results never arrived", visible_q.size()));
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT and its signals
    // ------------------------------------------------------------------
    bit                                   clk;
    logic                                 rst_n        = 1'b0;
    logic                                 cfg_valid    = 1'b0;
    logic                                 cfg_ready;
    logic [afc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index    = '0;
    logic [afc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data     = '0;
    logic                                 box_valid    = 1'b0;
    logic                                 box_ready;
    afc_pkg::coord_t                      box_min_x    = '0;
    afc_pkg::coord_t                      box_min_y    = '0;
    afc_pkg::coord_t                      box_min_z    = '0;
    afc_pkg::coord_t                      box_max_x    = '0;
    afc_pkg::coord_t                      box_max_y    = '0;
    afc_pkg::coord_t                      box_max_z    = '0;
    logic                                 result_valid;
    logic                                 result_ready = 1'b0;
    logic                                 visible;

    cull_scoreboard sb;
    int             burst_left    = 0;
    int             results_seen  = 0;
    int             idle_cycles   = 0;

    aabb_frustum_cull dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .box_valid    (box_valid),
        .box_ready    (box_ready),
        .box_min_x    (box_min_x),
        .box_min_y    (box_min_y),
        .box_min_z    (box_min_z),
        .box_max_x    (box_max_x),
        .box_max_y    (box_max_y),
        .box_max_z    (box_max_z),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .visible      (visible)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: handshakes are sampled at the rising edge, before the
    // block's registers update. Also runs the no-progress watchdog.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        afc_pkg::box_t seen_box;
        bit   moved;
        moved = 1'b0;
        if (rst_n && box_valid && box_ready) begin
            seen_box.lo_x = box_min_x;
            seen_box.lo_y = box_min_y;
            seen_box.lo_z = box_min_z;
            seen_box.hi_x = box_max_x;
            seen_box.hi_y = box_max_y;
            seen_box.hi_z = box_max_z;
            sb.note_box(seen_box);
            moved = 1'b1;
        end
        if (rst_n && result_valid && result_ready) begin
            sb.check_visible(visible);
            results_seen++;
            moved = 1'b1;
        end
        if (rst_n && cfg_valid && cfg_ready)
            moved = 1'b1;
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stalls on its own pattern, in segments of random mode.
    // Once enough results have gone by it holds off for a long stretch
    // so the chain fills and box_ready drops while boxes keep coming.
    // ------------------------------------------------------------------
    initial
    begin
        int mode;
        int len;
        bit held;
        held = 1'b0;
        forever begin
            if (!held && results_seen >= 400) begin
                held = 1'b1;
                @(negedge clk);
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else begin
                mode = $urandom_range(0, 4);
                len  = $urandom_range(1, 40);
                for (int k = 0; k < len; k++) begin
                    @(negedge clk);
                    case (mode) inside
                        0, 4:    result_ready <= 1'b1;
                        1:       result_ready <= 1'($urandom_range(0, 1));
                        2:       result_ready <= ($urandom_range(0, 5) == 0);
                        default: result_ready <= k[0];
                    endcase
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic afc_pkg::column_t pack_col(afc_pkg::entry_t r0, afc_pkg::entry_t r1,
                                                  afc_pkg::entry_t r2, afc_pkg::entry_t r3);
        return {r3, r2, r1, r0};
    endfunction

    function automatic afc_pkg::entry_t rnd_entry(int mag);
        return afc_pkg::entry_t'(int'($urandom_range(0, 2 * mag)) - mag);
    endfunction

    function automatic afc_pkg::box_t mk_box(int lx, int ly, int lz, int hx, int hy, int hz);
        afc_pkg::box_t b;
        b.lo_x = afc_pkg::coord_t'(lx);
        b.lo_y = afc_pkg::coord_t'(ly);
        b.lo_z = afc_pkg::coord_t'(lz);
        b.hi_x = afc_pkg::coord_t'(hx);
        b.hi_y = afc_pkg::coord_t'(hy);
        b.hi_z = afc_pkg::coord_t'(hz);
        return b;
    endfunction

    // Mix of raw 16-bit noise, ordered boxes of moderate size, tiny boxes
    // around the origin (where sums land near zero) and inverted boxes.
    function automatic afc_pkg::box_t rand_box();
        afc_pkg::box_t b;
        int   kind;
        int   cx, cy, cz, ex, ey, ez;
        kind = $urandom_range(0, 9);
        if (kind <= 2) begin
            b = {$urandom, $urandom, $urandom};
        end
        else if (kind <= 8) begin
            if (kind <= 6) begin
                cx = int'($urandom_range(0, 4000)) - 2000;
                cy = int'($urandom_range(0, 4000)) - 2000;
                cz = int'($urandom_range(0, 4000)) - 2000;
                ex = $urandom_range(0, 500);
                ey = $urandom_range(0, 500);
                ez = $urandom_range(0, 500);
            end
            else begin
                cx = int'($urandom_range(0, 16)) - 8;
                cy = int'($urandom_range(0, 16)) - 8;
                cz = int'($urandom_range(0, 16)) - 8;
                ex = $urandom_range(0, 4);
                ey = $urandom_range(0, 4);
                ez = $urandom_range(0, 4);
            end
            b = mk_box(cx, cy, cz, cx + ex, cy + ey, cz + ez);
        end
        else begin
            // inverted: min x above max x, min y and z at or above max
            cx = int'($urandom_range(0, 2000)) - 1000;
            cy = int'($urandom_range(0, 2000)) - 1000;
            cz = int'($urandom_range(0, 2000)) - 1000;
            b  = mk_box(cx, cy, cz, cx - int'($urandom_range(1, 300)),
                        cy - int'($urandom_range(0, 300)), cz - int'($urandom_range(0, 300)));
        end
        return b;
    endfunction

    // Offer one box. The sender runs in bursts; between bursts valid drops
    // for a random gap (sometimes none, so back-to-back stretches occur).
    task automatic send_box(afc_pkg::box_t b);
        int gap;
        int r;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 200)
                                                      : $urandom_range(1, 24);
            r   = $urandom_range(0, 9);
            gap = (r < 3) ? 0 : (r < 9) ? $urandom_range(1, 6) : $urandom_range(10, 30);
            if (gap > 0) begin
                @(negedge clk);
                box_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        box_valid <= 1'b1;
        box_min_x <= b.lo_x;
        box_min_y <= b.lo_y;
        box_min_z <= b.lo_z;
        box_max_x <= b.hi_x;
        box_max_y <= b.hi_y;
        box_max_z <= b.hi_z;
        do @(posedge clk); while (!box_ready);
    endtask

    // Drop valid, wait for every pending result, then let the chain empty.
    task automatic end_phase();
        @(negedge clk);
        box_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [afc_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             afc_pkg::column_t data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_column(idx, data);
    endtask

    // Writes all four columns plus one out-of-range index that must be
    // ignored, then lets the registered plane terms settle.
    task automatic load_matrix(afc_pkg::column_t c0, afc_pkg::column_t c1,
                               afc_pkg::column_t c2, afc_pkg::column_t c3);
        write_reg(afc_pkg::REG_MATRIX_COL0, c0);
        write_reg(afc_pkg::REG_MATRIX_COL1, c1);
        write_reg(afc_pkg::REG_MATRIX_COL2, c2);
        write_reg(afc_pkg::REG_MATRIX_COL3, c3);
        write_reg(afc_pkg::CFG_INDEX_WIDTH'($urandom_range(
                      int'(afc_pkg::REG_MATRIX_COL3) + 1,
                      (1 << afc_pkg::CFG_INDEX_WIDTH) - 1)),
                  {$urandom, $urandom});
        @(negedge clk);
        cfg_valid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_kind(matrix_kind_t kind);
        afc_pkg::entry_t e[afc_pkg::NUM_COLS][afc_pkg::NUM_ROWS];
        for (int c = 0; c < afc_pkg::NUM_COLS; c++) begin
            for (int r = 0; r < afc_pkg::NUM_ROWS; r++) begin
                case (kind)
                    MX_RANDOM: e[c][r] = afc_pkg::entry_t'($urandom);
                    MX_MAX:    e[c][r] = afc_pkg::entry_t'(16'h7FFF);
                    MX_MIN:    e[c][r] = afc_pkg::entry_t'(16'h8000);
                    MX_MIXED:  e[c][r] = (r == 3 || $urandom_range(0, 1))
                                         ? afc_pkg::entry_t'(16'h7FFF)
                                         : afc_pkg::entry_t'(16'h8000);
                    MX_PROJ:   e[c][r] = rnd_entry(200);
                    MX_FLAT:   e[c][r] = rnd_entry(32000);
                    MX_SMALL:  e[c][r] = rnd_entry(64);
                    default:   e[c][r] = '0;
                endcase
            end
        end
        if (kind == MX_PROJ) begin
            // rough perspective: x/y scale, z remap, w = -z, plus noise
            e[0][0] = afc_pkg::entry_t'($urandom_range(1000, 8000));
            e[1][1] = afc_pkg::entry_t'($urandom_range(1000, 8000));
            e[2][2] = afc_pkg::entry_t'(-int'($urandom_range(4096, 5000)));
            e[2][3] = afc_pkg::entry_t'(-4096);
            e[3][2] = afc_pkg::entry_t'(-int'($urandom_range(0, 4000)));
            e[3][3] = rnd_entry(8000);
        end
        if (kind == MX_FLAT) begin
            // row 0 = -row 3 and row 1 = row 3: left and top normals vanish
            for (int c = 0; c < afc_pkg::NUM_COLS; c++) begin
                e[c][3] = rnd_entry(16000);
                e[c][0] = -e[c][3];
                e[c][1] = e[c][3];
            end
        end
        load_matrix(pack_col(e[0][0], e[0][1], e[0][2], e[0][3]),
                    pack_col(e[1][0], e[1][1], e[1][2], e[1][3]),
                    pack_col(e[2][0], e[2][1], e[2][2], e[2][3]),
                    pack_col(e[3][0], e[3][1], e[3][2], e[3][3]));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        matrix_kind_t plan[10];
        plan = '{MX_RANDOM, MX_PROJ, MX_MIXED, MX_FLAT, MX_SMALL,
                 MX_MAX, MX_ZERO, MX_RANDOM, MX_PROJ, MX_MIN};
        sb = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset matrix is all zero: every normal vanishes, every box visible.
        send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
        send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(mk_box(32767, 32767, 32767, -32768, -32768, -32768));
        end_phase();

        // Left normal (1,0,0), right normal (-1,0,0), d = 0, other planes flat.
        // Exercises the sum exactly zero (kept) against one below (culled).
        load_matrix(pack_col(afc_pkg::entry_t'(1), '0, '0, '0), '0, '0, '0);
        send_box(mk_box(-10, 0, 0, 0, 0, 0));
        send_box(mk_box(-10, 0, 0, -1, 0, 0));
        send_box(mk_box(1, 0, 0, 10, 0, 0));
        send_box(mk_box(0, -32768, -32768, 10, 32767, 32767));
        send_box(mk_box(5, 0, 0, -5, 0, 0));              // inverted box
        send_box(mk_box(-32768, 32767, -32768, 32767, -32768, 32767));
        end_phase();

        // Largest positive entries: plus planes at full scale, minus planes flat.
        load_kind(MX_MAX);
        send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
        send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        end_phase();

        // Most negative entries: plus-plane normals negative, min corner is chosen; minus planes flat.
        load_kind(MX_MIN);
        send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
        send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        end_phase();

        // All normals zero with d strongly negative: still visible.
        load_matrix('0, '0, '0, pack_col('0, '0, '0, afc_pkg::entry_t'(16'h8000)));
        send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
        send_box(mk_box(100, -100, 7, 200, 50, 9));
        end_phase();

        // Random part: one matrix setting per phase.
        foreach (plan[ph]) begin
            load_kind(plan[ph]);
            repeat (PHASE_ITEMS) send_box(rand_box());
            end_phase();
        end

        sb.close_out();
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
